// ----- design/line_counter_interrupt_controller_top_defines.svh -----
// Assertion macros for the line counter interrupt controller.
// Used by the port checker; depends on nothing else.
`ifndef LINE_COUNTER_INTERRUPT_CONTROLLER_TOP_DEFINES_SVH
`define LINE_COUNTER_INTERRUPT_CONTROLLER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LCIC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lcic check failed");

// Next-cycle implication, disabled during reset.
`define LCIC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lcic check failed");

`endif

// ----- design/lcic_pkg.sv -----
// Shared types and constants of the line counter interrupt controller.
// No dependencies.
`default_nettype none

package lcic_pkg;

   localparam int LINE_W = 9;
   localparam int CNT_W  = 8;
   localparam int LVL_W  = 3;
   localparam int ADDR_W = 4;
   localparam int DATA_W = 32;

   // item commands
   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_ACK  = 1'b1;

   // priority levels
   localparam logic [LVL_W-1:0] LEVEL_NONE = 3'd0;
   localparam logic [LVL_W-1:0] LEVEL_HINT = 3'd4;
   localparam logic [LVL_W-1:0] LEVEL_VINT = 3'd6;

   // register indexes (byte address / 4)
   localparam logic [1:0] REG_HINT_ENABLE = 2'd0;
   localparam logic [1:0] REG_VINT_ENABLE = 2'd1;
   localparam logic [1:0] REG_HINT_RELOAD = 2'd2;

   typedef struct packed {
      logic             command;
      logic [LVL_W-1:0] ack_level;
   } req_type;

   typedef struct packed {
      logic [LVL_W-1:0]  ipl;
      logic              frame_flag;
      logic [LINE_W-1:0] line_index;
   } rsp_type;

   typedef struct packed {
      logic             hint_enable;
      logic             vint_enable;
      logic [CNT_W-1:0] hint_reload;
   } cfg_type;

endpackage

`default_nettype wire

// ----- design/lcic_regs.sv -----
// Configuration registers behind the APB-style port.
// Depends on lcic_pkg.
`default_nettype none

module lcic_regs (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         psel,
   input  wire logic                         penable,
   input  wire logic                         pwrite,
   input  wire logic [lcic_pkg::ADDR_W-1:0]  paddr,
   input  wire logic [lcic_pkg::DATA_W-1:0]  pwdata,
   output logic      [lcic_pkg::DATA_W-1:0]  prdata,
   output lcic_pkg::cfg_type                 cfg
);
   import lcic_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       wr_en;
   logic [1:0] reg_idx;

   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[3:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_HINT_ENABLE: cfg_in.hint_enable = pwdata[0];
            REG_VINT_ENABLE: cfg_in.vint_enable = pwdata[0];
            REG_HINT_RELOAD: cfg_in.hint_reload = pwdata[CNT_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_idx)
         REG_HINT_ENABLE: prdata = {{(DATA_W-1){1'b0}}, cfg_ff.hint_enable};
         REG_VINT_ENABLE: prdata = {{(DATA_W-1){1'b0}}, cfg_ff.vint_enable};
         REG_HINT_RELOAD: prdata = {{(DATA_W-CNT_W){1'b0}}, cfg_ff.hint_reload};
         default:         prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ----- design/lcic_core.sv -----
// Line/interrupt state and its combinational next-state update for one item.
// Depends on lcic_pkg.
`default_nettype none

module lcic_core #(
   parameter int TOTAL_LINES  = 262,
   parameter int ACTIVE_LINES = 224
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              update,
   input  wire lcic_pkg::req_type item,
   input  wire lcic_pkg::cfg_type cfg,
   output lcic_pkg::rsp_type      result
);
   import lcic_pkg::*;

   localparam logic [LINE_W:0]   TOTAL_LIM  = (LINE_W+1)'(TOTAL_LINES);
   localparam logic [LINE_W-1:0] ACTIVE_LIM = LINE_W'(ACTIVE_LINES);

   logic [LINE_W-1:0] line_ff, line_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              hpend_ff, hpend_in;
   logic              vpend_ff, vpend_in;
   logic              vflag_ff, vflag_in;
   logic [LINE_W:0]   line_inc;
   logic [LINE_W-1:0] shown_line;

   assign line_inc = {1'b0, line_ff} + (LINE_W+1)'(1);

   always_comb begin
      line_in    = line_ff;
      cnt_in     = cnt_ff;
      hpend_in   = hpend_ff;
      vpend_in   = vpend_ff;
      vflag_in   = vflag_ff;
      shown_line = line_ff;
      if (item.command == CMD_TICK) begin
         if (line_ff < ACTIVE_LIM) begin
            if (cnt_ff == '0) begin
               cnt_in = cfg.hint_reload;
               if (line_ff != '0) hpend_in = 1'b1;
            end else begin
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end else begin
            cnt_in = cfg.hint_reload;
         end
         // first blanking line
         if (line_ff == ACTIVE_LIM) begin
            vpend_in = 1'b1;
            vflag_in = 1'b1;
         end
         if (line_inc >= TOTAL_LIM || line_inc[LINE_W]) begin
            line_in = '0;
         end else begin
            line_in = line_inc[LINE_W-1:0];
         end
      end else begin
         if (item.ack_level == LEVEL_VINT) begin
            vpend_in = 1'b0;
            vflag_in = 1'b0;
         end else if (item.ack_level == LEVEL_HINT) begin
            hpend_in = 1'b0;
         end
      end
   end

   always_comb begin
      if (vpend_in && cfg.vint_enable) begin
         result.ipl = LEVEL_VINT;
      end else if (hpend_in && cfg.hint_enable) begin
         result.ipl = LEVEL_HINT;
      end else begin
         result.ipl = LEVEL_NONE;
      end
      result.frame_flag = vflag_in;
      result.line_index = shown_line;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff  <= '0;
         cnt_ff   <= '0;
         hpend_ff <= 1'b0;
         vpend_ff <= 1'b0;
         vflag_ff <= 1'b0;
      end else if (update) begin
         line_ff  <= line_in;
         cnt_ff   <= cnt_in;
         hpend_ff <= hpend_in;
         vpend_ff <= vpend_in;
         vflag_ff <= vflag_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/line_counter_interrupt_controller_top.sv -----
// Top level of the line counter interrupt controller: handshake, input and
// result registers. Depends on lcic_pkg, lcic_regs and lcic_core.
//
// Usage:
//  - req channel: one item per handshake, a scanline tick (command 0) or an
//    interrupt acknowledge (command 1, level in ack_level). Accepted at an
//    edge with req_valid high and req_stall low.
//  - rsp channel: exactly one result item per request item, in order:
//    interrupt level (0, 4 or 6), frame flag and scanline index.
//  - Order: an accepted item sits in the input register; its result is
//    registered when the item advances and shown from then on.
//  - Throughput: one item per cycle unless rsp_stall holds a waiting
//    result. The input register and the result register form a two-stage
//    pipe; the state update is one short step between them.
//  - Stall: while rsp_stall holds a waiting result, the result is held
//    steady and one more item may still park in the input register; after
//    that req_stall is raised.
//  - Reset (synchronous, active high): line, counter, pending flags,
//    frame flag and config registers go to zero; both pipe stages empty.
//  - Registers at byte addresses 0, 4, 8: hint_enable, vint_enable,
//    hint_reload. Write only while the block is idle.
`default_nettype none

module line_counter_interrupt_controller_top #(
   parameter int TOTAL_LINES  = 262,
   parameter int ACTIVE_LINES = 224
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // request channel
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire lcic_pkg::req_type            req_data,
   // result channel
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output lcic_pkg::rsp_type                 rsp_data,
   // configuration
   input  wire logic                         psel,
   input  wire logic                         penable,
   input  wire logic                         pwrite,
   input  wire logic [lcic_pkg::ADDR_W-1:0]  paddr,
   input  wire logic [lcic_pkg::DATA_W-1:0]  pwdata,
   output logic      [lcic_pkg::DATA_W-1:0]  prdata,
   output logic                              pready
);
   import lcic_pkg::*;

   cfg_type cfg;
   rsp_type core_result;

   // input stage
   logic    in_valid_ff, in_valid_in;
   req_type in_item_ff, in_item_in;
   // result stage
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff, out_data_in;

   logic    advance;   // item moves from input register to result register
   logic    req_take;

   assign pready = 1'b1;

   lcic_regs u_regs (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .cfg     (cfg)
   );

   lcic_core #(
      .TOTAL_LINES  (TOTAL_LINES),
      .ACTIVE_LINES (ACTIVE_LINES)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .update (advance),
      .item   (in_item_ff),
      .cfg    (cfg),
      .result (core_result)
   );

   // result register frees up when empty or being taken this cycle
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_item_in  = req_data;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_data_in  = core_result;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

`default_nettype wire

// ----- design/lcic_checker.sv -----
// Port-level checks for the line counter interrupt controller, bound to
// the top level. Depends on lcic_pkg and the defines header.
`default_nettype none
`include "line_counter_interrupt_controller_top_defines.svh"

module lcic_checker #(
   parameter int TOTAL_LINES = 262
) (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire lcic_pkg::rsp_type rsp_data,
   input wire logic              pready
);
   import lcic_pkg::*;

   localparam logic [LINE_W:0] TOTAL_LIM = (LINE_W+1)'(TOTAL_LINES);

   `LCIC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_data))
   `LCIC_ASSERT_NOW(a_ipl_code, clock, reset, rsp_valid,
      rsp_data.ipl == LEVEL_NONE || rsp_data.ipl == LEVEL_HINT || rsp_data.ipl == LEVEL_VINT)
   `LCIC_ASSERT_NOW(a_vint_flag, clock, reset, rsp_valid && rsp_data.ipl == LEVEL_VINT,
      rsp_data.frame_flag)
   `LCIC_ASSERT_NOW(a_line_range, clock, reset, rsp_valid,
      {1'b0, rsp_data.line_index} < TOTAL_LIM && pready)

endmodule

bind line_counter_interrupt_controller_top lcic_checker #(
   .TOTAL_LINES (TOTAL_LINES)
) u_lcic_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data),
   .pready    (pready)
);

`default_nettype wire
